### hdl/assert_macros.svh
// Assertion macros for the RTL that checks itself (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled during reset
`define CHK_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// clocked invariant, disabled during reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

### hdl/sscc_pkg.sv
// Types and constants of the stepper step-count controller
package sscc_pkg;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_MOVE_ABS   = 2'd0,
    OP_MOVE_REL   = 2'd1,
    OP_STOP       = 2'd2,
    OP_PULSE_DONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MOTOR = 2'd1,
    ST_BUSY      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_PULSES_PER_DEG = 2'd0,
    REG_MAX_ANGLE      = 2'd1,
    REG_PARK_ANGLE     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  localparam logic [15:0] PPD_RESET      = 16'd4267;
  localparam logic [14:0] MAX_ANGLE_RESET = 15'd15360;
  localparam logic [15:0] PARK_RESET     = 16'd2560;

  typedef struct packed {
    logic [15:0]        pulses_per_degree_q8;
    logic [14:0]        max_angle_q8;
    logic signed [15:0] park_angle_q8;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         motor_index;
    logic signed [15:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         motor_echo;
    status_t            status;
    logic               dir_write;
    logic               direction;
    logic               start_pulses;
    logic               stop_pulses;
    logic [15:0]        pulses_left;
    logic signed [15:0] angle_now;
  } res_t;

endpackage

### hdl/sscc_if.sv
// Command and result channel interfaces
interface sscc_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         motor_index;
  logic signed [15:0] angle;

  modport source (output valid, op, motor_index, angle, input ready);
  modport sink (input valid, op, motor_index, angle, output ready);
endinterface

interface sscc_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         motor_echo;
  logic [1:0]         status;
  logic               dir_write;
  logic               direction;
  logic               start_pulses;
  logic               stop_pulses;
  logic [15:0]        pulses_left;
  logic signed [15:0] angle_now;

  modport source (output valid, motor_echo, status, dir_write, direction, start_pulses,
                  stop_pulses, pulses_left, angle_now, input ready);
  modport sink (input valid, motor_echo, status, dir_write, direction, start_pulses,
                stop_pulses, pulses_left, angle_now, output ready);
endinterface

### hdl/sscc_cfg_regs.sv
// Configuration registers with write port
module sscc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [1:0]                       cfg_index,
  input  logic [sscc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sscc_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_degree_q8 <= sscc_pkg::PPD_RESET;
      cfg.max_angle_q8         <= sscc_pkg::MAX_ANGLE_RESET;
      cfg.park_angle_q8        <= sscc_pkg::PARK_RESET;
    end else if (cfg_write_en) begin
      unique case (sscc_pkg::reg_idx_t'(cfg_index))
        sscc_pkg::REG_PULSES_PER_DEG: cfg.pulses_per_degree_q8 <= cfg_data;
        sscc_pkg::REG_MAX_ANGLE:      cfg.max_angle_q8         <= cfg_data[14:0];
        sscc_pkg::REG_PARK_ANGLE:     cfg.park_angle_q8        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/sscc_in_stage.sv
// Input register of the command channel
module sscc_in_stage (
  input  logic           clk,
  input  logic           rst,
  sscc_cmd_if.sink       cmd,
  input  logic           take,
  output logic           item_valid,
  output sscc_pkg::cmd_t item
);

  assign cmd.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.op          <= sscc_pkg::op_t'(cmd.op);
      item.motor_index <= cmd.motor_index;
      item.angle       <= cmd.angle;
    end
  end

endmodule

### hdl/sscc_exec.sv
// Per-motor state, command evaluation and result register
module sscc_exec #(
  parameter int unsigned MOTORS = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  sscc_pkg::cfg_t cfg,
  input  logic           item_valid,
  input  sscc_pkg::cmd_t item,
  output logic           take,
  sscc_res_if.source     res
);

  localparam int unsigned IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [15:0]        pulse_counter [MOTORS];
  logic signed [15:0] motor_angle   [MOTORS];

  logic               res_valid;
  sscc_pkg::res_t     res_q;

  logic [IDX_W-1:0]   idx;
  logic               motor_ok;
  logic [15:0]        cnt;
  logic signed [15:0] agl;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [31:0]        prod;
  logic [15:0]        pulses;
  logic [15:0]        cnt_dec;
  logic               out_of_range;
  logic               wr;
  logic [15:0]        cnt_new;
  logic signed [15:0] ang_new;
  sscc_pkg::res_t     r;

  assign take     = item_valid && (!res_valid || res.ready);
  assign motor_ok = {1'b0, item.motor_index} < 5'(MOTORS);
  assign idx      = item.motor_index[IDX_W-1:0];
  assign cnt      = motor_ok ? pulse_counter[idx] : 16'd0;
  assign agl      = motor_ok ? motor_angle[idx] : 16'sd0;

  always_comb begin
    diff = (item.op == sscc_pkg::OP_MOVE_ABS)
         ? (17'(item.angle) - 17'(agl))
         : 17'(item.angle);
    mag          = diff[16] ? (17'd0 - 17'(diff)) : 17'(diff);
    prod         = mag[15:0] * cfg.pulses_per_degree_q8;
    pulses       = prod[31:16];
    cnt_dec      = (cnt == 16'd0) ? 16'd0 : cnt - 16'd1;
    out_of_range = item.angle[15] || (item.angle[14:0] > cfg.max_angle_q8);
  end

  always_comb begin
    r              = '0;
    r.motor_echo   = item.motor_index;
    r.status       = sscc_pkg::ST_OK;
    wr             = 1'b0;
    cnt_new        = cnt;
    ang_new        = agl;
    if (!motor_ok) begin
      r.status = sscc_pkg::ST_BAD_MOTOR;
    end else begin
      unique case (item.op) inside
        sscc_pkg::OP_MOVE_ABS, sscc_pkg::OP_MOVE_REL: begin
          if (cnt != 16'd0) begin
            r.status = sscc_pkg::ST_BUSY;
          end else if (item.op == sscc_pkg::OP_MOVE_ABS && out_of_range) begin
            r.status = sscc_pkg::ST_RANGE;
          end else begin
            wr             = 1'b1;
            r.dir_write    = 1'b1;
            r.direction    = diff[16];
            cnt_new        = pulses;
            r.start_pulses = (pulses != 16'd0);
            if (item.op == sscc_pkg::OP_MOVE_ABS) begin
              ang_new = item.angle;
            end
          end
        end
        sscc_pkg::OP_STOP: begin
          wr            = 1'b1;
          cnt_new       = 16'd0;
          ang_new       = cfg.park_angle_q8;
          r.stop_pulses = 1'b1;
        end
        sscc_pkg::OP_PULSE_DONE: begin
          wr            = 1'b1;
          cnt_new       = cnt_dec;
          r.stop_pulses = (cnt_dec == 16'd0);
        end
        default: ;
      endcase
      r.pulses_left = cnt_new;
      r.angle_now   = ang_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        pulse_counter[i] <= 16'd0;
        motor_angle[i]   <= 16'sd0;
      end
    end else if (take && wr) begin
      pulse_counter[idx] <= cnt_new;
      motor_angle[idx]   <= ang_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res.ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= r;
    end
  end

  assign res.valid        = res_valid;
  assign res.motor_echo   = res_q.motor_echo;
  assign res.status       = res_q.status;
  assign res.dir_write    = res_q.dir_write;
  assign res.direction    = res_q.direction;
  assign res.start_pulses = res_q.start_pulses;
  assign res.stop_pulses  = res_q.stop_pulses;
  assign res.pulses_left  = res_q.pulses_left;
  assign res.angle_now    = res_q.angle_now;

endmodule

### hdl/stepper_step_count_controller_core.sv
// Top level of the stepper step-count controller
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        op, motor_index, angle
//   res      out  valid/ready        motor_echo, status, flags, pulses_left, angle_now
//   cfg      in   cfg_write_en       cfg_index, cfg_data
//
// One command per cycle while results are taken; each result passes the input register and the result register.
// The limit is the single evaluate stage: state read, 16x16 multiply, update.
// Synchronous reset clears all counts and angles and loads register defaults.
// A stalled result holds the input register; cmd.ready drops once both are full.
`include "assert_macros.svh"

module stepper_step_count_controller_core #(
  parameter int unsigned MOTORS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  sscc_cmd_if.sink                        cmd,
  sscc_res_if.source                      res,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [sscc_pkg::CFG_DATA_W-1:0] cfg_data
);

  sscc_pkg::cfg_t cfg;
  sscc_pkg::cmd_t item;
  logic           item_valid;
  logic           take;

  sscc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  sscc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sscc_exec #(
    .MOTORS (MOTORS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res        (res)
  );

  `CHK_IMPL(a_full_stall, item_valid && res.valid && !res.ready, !cmd.ready, "ready while full")
  `CHK_IMPL(a_bad_motor, res.valid && res.status == sscc_pkg::ST_BAD_MOTOR,
            !res.dir_write && !res.stop_pulses && res.pulses_left == 16'd0, "bad motor result")
  `CHK_IMPL(a_start, res.valid && res.start_pulses,
            res.dir_write && res.pulses_left != 16'd0, "start without count")
  `CHK_IMPL(a_reject, res.valid && res.status != sscc_pkg::ST_OK,
            !res.dir_write && !res.start_pulses, "rejected move drove pins")

endmodule
